// ----- rtl/sorted_table_insert_search_remove_macros.svh -----
// assertion macros for the sorted table block
`ifndef SORTED_TABLE_INSERT_SEARCH_REMOVE_MACROS_SVH
`define SORTED_TABLE_INSERT_SEARCH_REMOVE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define STIS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted table assertion failed");
// next-cycle implication
`define STIS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted table assertion failed");
`else
`define STIS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STIS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/stis_pkg.sv -----
// shared types and constants of the sorted table block
package stis_pkg;

  localparam int unsigned DataW = 32;

  typedef logic [1:0] op_t;
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_SEARCH = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK     = 2'd0;
  localparam status_t STAT_ABSENT = 2'd1;
  localparam status_t STAT_FULL   = 2'd2;

  // smallest value reported for an empty table (-9999999)
  localparam logic [DataW-1:0] EMPTY_MARK = 32'hFF67_6981;

  typedef enum logic [1:0] {
    RD_IDX  = 2'd0,
    RD_PREV = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_e;

  typedef enum logic {
    WR_VALUE = 1'b0,
    WR_RDATA = 1'b1
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    logic    idx_clr;
    logic    idx_set_cnt;
    logic    idx_inc;
    logic    idx_dec;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    st_set;
    status_t st_val;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic idx_zero;
    logic idx_end;
    logic idx_last;
    logic rd_eq;
    logic rd_gt;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/stis_ram.sv -----
// generic single-write single-read ram with registered read data
module stis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/stis_ctrl.sv -----
// controller state machine of the sorted table
module stis_ctrl
  import stis_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DISPATCH = 8'b0000_0010,
    ST_INS_CHK  = 8'b0000_0100,
    ST_INS_CMP  = 8'b0000_1000,
    ST_SCAN_CHK = 8'b0001_0000,
    ST_SCAN_CMP = 8'b0010_0000,
    ST_DEL_CHK  = 8'b0100_0000,
    ST_DEL_WR   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   resp_q, resp_d;

  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_IDX;
    cmd_o.wr_sel = WR_VALUE;
    in_ready_o = 1'b0;

    if (resp_q) begin
      // wait for the output register, then go back to idle
      if (sts_i.out_free) begin
        cmd_o.out_load = 1'b1;
        resp_d  = 1'b0;
        state_d = ST_IDLE;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          priority if (sts_i.op == OP_INSERT) begin
            if (sts_i.full) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = STAT_FULL;
              resp_d       = 1'b1;
            end else begin
              cmd_o.idx_set_cnt = 1'b1;
              state_d           = ST_INS_CHK;
            end
          end else if (sts_i.op == OP_SEARCH || sts_i.op == OP_REMOVE) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_SCAN_CHK;
          end else begin
            cmd_o.st_set = 1'b1;
            cmd_o.st_val = STAT_ABSENT;
            resp_d       = 1'b1;
          end
        end
        ST_INS_CHK: begin
          if (sts_i.idx_zero) begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.cnt_inc = 1'b1;
            cmd_o.st_set  = 1'b1;
            cmd_o.st_val  = STAT_OK;
            resp_d        = 1'b1;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_PREV;
            state_d      = ST_INS_CMP;
          end
        end
        ST_INS_CMP: begin
          if (sts_i.rd_gt) begin
            // larger entry moves up one slot
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_sel  = WR_RDATA;
            cmd_o.idx_dec = 1'b1;
            state_d       = ST_INS_CHK;
          end else begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.cnt_inc = 1'b1;
            cmd_o.st_set  = 1'b1;
            cmd_o.st_val  = STAT_OK;
            resp_d        = 1'b1;
          end
        end
        ST_SCAN_CHK: begin
          if (sts_i.idx_end) begin
            cmd_o.st_set = 1'b1;
            cmd_o.st_val = STAT_ABSENT;
            resp_d       = 1'b1;
          end else begin
            cmd_o.rd_en = 1'b1;
            state_d     = ST_SCAN_CMP;
          end
        end
        ST_SCAN_CMP: begin
          priority if (sts_i.rd_eq) begin
            if (sts_i.op == OP_SEARCH) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = STAT_OK;
              resp_d       = 1'b1;
            end else begin
              state_d = ST_DEL_CHK;
            end
          end else if (sts_i.rd_gt) begin
            cmd_o.st_set = 1'b1;
            cmd_o.st_val = STAT_ABSENT;
            resp_d       = 1'b1;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_SCAN_CHK;
          end
        end
        ST_DEL_CHK: begin
          if (sts_i.idx_last) begin
            cmd_o.cnt_dec = 1'b1;
            cmd_o.st_set  = 1'b1;
            cmd_o.st_val  = STAT_OK;
            resp_d        = 1'b1;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_NEXT;
            state_d      = ST_DEL_WR;
          end
        end
        ST_DEL_WR: begin
          // following entry moves down one slot
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = WR_RDATA;
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_DEL_CHK;
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      resp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

endmodule

// ----- rtl/stis_datapath.sv -----
// datapath of the sorted table: entry ram, index, count and output register
module stis_datapath
  import stis_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  op_t              in_op_i,
  input  logic [DataW-1:0] in_value_i,
  input  logic             out_ready_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic             out_valid_o,
  output status_t          out_status_o,
  output logic [4:0]       out_count_o,
  output logic             out_empty_o,
  output logic [DataW-1:0] out_smallest_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  op_t              op_q;
  logic [DataW-1:0] value_q;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    count_q, count_d;
  logic [DataW-1:0] smallest_q;
  status_t          st_q;
  logic             out_valid_q;
  status_t          out_status_q;
  logic [4:0]       out_count_q;
  logic             out_empty_q;
  logic [DataW-1:0] out_smallest_q;

  logic [CW-1:0]    raddr_full;
  logic [DataW-1:0] rdata;
  logic [DataW-1:0] wdata;
  logic [31:0]      count_ext;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX:  raddr_full = idx_q;
      RD_PREV: raddr_full = idx_q - CW'(1);
      RD_NEXT: raddr_full = idx_q + CW'(1);
      default: raddr_full = idx_q;
    endcase
  end

  assign wdata = (cmd_i.wr_sel == WR_RDATA) ? rdata : value_q;

  stis_ram #(
    .WIDTH(DataW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(idx_q[AW-1:0]),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr_full[AW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    idx_d = idx_q;
    priority if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_set_cnt) begin
      idx_d = count_q;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - CW'(1);
    end
    count_d = count_q;
    priority if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      count_q <= count_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign count_ext = 32'(count_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_op_i;
      value_q <= in_value_i;
    end
    // mirror of entry zero
    if (cmd_i.wr_en && idx_q == '0) begin
      smallest_q <= wdata;
    end
    if (cmd_i.st_set) begin
      st_q <= cmd_i.st_val;
    end
    if (cmd_i.out_load) begin
      out_status_q   <= st_q;
      out_count_q    <= count_ext[4:0];
      out_empty_q    <= (count_q == '0);
      out_smallest_q <= (count_q == '0) ? EMPTY_MARK : smallest_q;
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.full     = (count_q == CW'(CAPACITY));
  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.idx_end  = (idx_q == count_q);
  assign sts_o.idx_last = ((idx_q + CW'(1)) == count_q);
  assign sts_o.rd_eq    = (rdata == value_q);
  assign sts_o.rd_gt    = ($signed(rdata) > $signed(value_q));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_count_o    = out_count_q;
  assign out_empty_o    = out_empty_q;
  assign out_smallest_o = out_smallest_q;

endmodule

// ----- rtl/sorted_table_insert_search_remove.sv -----
// top level of the sorted table with insert, search and remove
// keeps up to CAPACITY signed 32-bit values in ascending order in a ram, duplicates
// allowed; every input beat is one operation and gives exactly one output beat.
// one operation is worked at a time: the ram has one read port with registered data,
// so each entry visited is first read, then compared and moved. insert walks down
// from the top and moves every entry larger than the value up one slot. search scans
// up from slot zero until a hit, a larger entry or the end of the table. remove
// searches the same way and on a hit moves every entry behind it down one slot. a full
// insert or an unknown op is answered without a ram access. a result that finds the
// output register busy waits until it is free.
// the result waits in an output register, so a new beat is taken while it is unread.
// the entry ram needs no clearing, only entries below the count are ever read.
`include "sorted_table_insert_search_remove_macros.svh"

module sorted_table_insert_search_remove
  import stis_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // status[1:0], entry_count[6:2], is_empty[7],
                                      // smallest[39:8]
);

  cmd_t       cmd;
  sts_t       sts;
  status_t    out_status;
  logic [4:0] out_count;
  logic       out_empty;
  logic [31:0] out_smallest;

  // sequencing of scan, shift and response
  stis_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .sts_i     (sts),
    .in_ready_o(s_axis_tready),
    .cmd_o     (cmd)
  );

  // entry storage, index, count and result register
  stis_datapath #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_op_i       (s_axis_tuser),
    .in_value_i    (s_axis_tdata),
    .out_ready_i   (m_axis_tready),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_status_o  (out_status),
    .out_count_o   (out_count),
    .out_empty_o   (out_empty),
    .out_smallest_o(out_smallest)
  );

  assign m_axis_tdata = {out_smallest, out_empty, out_count, out_status};

  // a taken beat blocks the next one until the result is loaded
  `STIS_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni,
                   s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // empty results carry the empty marker
  `STIS_ASSERT_IMP(a_empty_mark, clk_i, rst_ni, m_axis_tvalid && out_empty,
                   out_count == 5'd0 && out_smallest == EMPTY_MARK)
  // a refused insert only happens at capacity
  `STIS_ASSERT_IMP(a_full_count, clk_i, rst_ni, m_axis_tvalid && out_status == STAT_FULL,
                   out_count == 5'(CAPACITY))

endmodule

// ----- tb/tb_sorted_table_insert_search_remove.sv -----
// self-checking testbench for the sorted table with insert, search and remove
module tb_sorted_table_insert_search_remove;
  import stis_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 16;
  localparam int unsigned RANDOM_ITEMS   = 1600;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // worst operation walks or shifts the whole table and may stall on the output
  localparam int unsigned DRAIN_CYCLES   = 100;
  // op code the block does not implement
  localparam op_t OP_UNUSED = 2'd3;

  typedef struct packed {
    status_t     status;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic [31:0] smallest;
  } table_result_t;

  typedef struct packed {
    op_t           op;
    logic [31:0]   value;
    logic          has_want;
    table_result_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // value[31:0]
  logic [1:0]  s_axis_tuser = '0;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // status[1:0], entry_count[6:2], is_empty[7],
                                    // smallest[39:8]

  // predictor state: stored values in ascending order
  logic signed [31:0] held_values[$];
  table_result_t      pending_results[$];
  stim_row_t          stim_rows[$];
  int unsigned        error_count = 0;
  int unsigned        send_idle_pct = 11;
  int unsigned        recv_idle_pct = 49;
  int unsigned        quiet_cycles = 0;

  sorted_table_insert_search_remove #(
    .CAPACITY(TABLE_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  // applies one operation to the held values and returns the result beat
  function automatic table_result_t predict_operation(input op_t op, input logic [31:0] value);
    table_result_t res;
    int            pos;
    res.status = STAT_ABSENT;
    case (op)
      OP_INSERT: begin
        if (held_values.size() >= TABLE_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          // new value goes after every equal entry
          pos = 0;
          while (pos < held_values.size() && held_values[pos] <= $signed(value)) pos++;
          held_values.insert(pos, value);
          res.status = STAT_OK;
        end
      end
      OP_SEARCH: begin
        foreach (held_values[i]) begin
          if (held_values[i] == $signed(value)) res.status = STAT_OK;
        end
      end
      OP_REMOVE: begin
        for (pos = 0; pos < held_values.size(); pos++) begin
          if (held_values[pos] == $signed(value)) begin
            held_values.delete(pos);
            res.status = STAT_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = 5'(held_values.size());
    res.is_empty    = (held_values.size() == 0);
    res.smallest    = (held_values.size() == 0) ? EMPTY_MARK : held_values[0];
    return res;
  endfunction

  // drives one beat, waits for it to be taken, then records what it should give
  task automatic issue_item(input int unsigned idx, input stim_row_t row);
    table_result_t res;
    // idling split in thirds: sender light, then receiver light, then none
    if (idx < (RANDOM_ITEMS + 25) / 3) begin
      send_idle_pct = 11;
      recv_idle_pct = 49;
    end else if (idx < 2 * (RANDOM_ITEMS + 25) / 3) begin
      send_idle_pct = 49;
      recv_idle_pct = 11;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= row.op;
    s_axis_tdata  <= row.value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = predict_operation(row.op, row.value);
    pending_results.push_back(row.has_want ? row.want : res);
  endtask

  // random op and value, alternating fill-heavy and drain-heavy stretches
  function automatic stim_row_t pick_random_item(input int unsigned idx);
    stim_row_t   row;
    int unsigned roll;
    int unsigned pick;
    logic        fill;
    fill = ((idx / 80) % 2) == 0;
    roll = $urandom_range(0, 99);
    if (roll < 3) row.op = OP_UNUSED;
    else if (roll < 15) row.op = OP_SEARCH;
    else if (roll < (fill ? 75 : 40)) row.op = OP_INSERT;
    else row.op = OP_REMOVE;
    pick = $urandom_range(0, 99);
    if (pick < 50 && held_values.size() > 0) begin
      // hit a stored value: duplicates, hits on search and remove
      row.value = held_values[$urandom_range(0, held_values.size() - 1)];
    end else if (pick < 70) begin
      row.value = 32'($urandom_range(0, 7)) - 32'd4;
    end else if (pick < 80) begin
      case ($urandom_range(0, 4))
        0:       row.value = 32'h8000_0000;
        1:       row.value = 32'h7FFF_FFFF;
        2:       row.value = EMPTY_MARK;
        3:       row.value = 32'hFFFF_FFFF;
        default: row.value = 32'h0000_0000;
      endcase
    end else begin
      row.value = $urandom;
    end
    row.has_want = 1'b0;
    row.want     = '0;
    return row;
  endfunction

  // result side: random ready and the check of each taken beat
  always @(posedge clk_i) begin
    table_result_t got;
    table_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      // the bus packs status lowest, the struct packs it highest
      got = {m_axis_tdata[1:0], m_axis_tdata[6:2], m_axis_tdata[7], m_axis_tdata[39:8]};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending: %h", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.entry_count != want.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    got.entry_count, want.entry_count));
        if (got.is_empty != want.is_empty)
          report_mismatch($sformatf("is_empty %0d, expected %0d", got.is_empty, want.is_empty));
        if (got.smallest != want.smallest)
          report_mismatch($sformatf("smallest %h, expected %h", got.smallest, want.smallest));
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned idx;
    // directed rows: empty table, odd op, extremes, duplicates, fill up to full
    stim_rows.push_back('{OP_SEARCH, 32'd0, 1'b1, '{STAT_ABSENT, 5'd0, 1'b1, EMPTY_MARK}});
    stim_rows.push_back('{OP_REMOVE, 32'd5, 1'b1, '{STAT_ABSENT, 5'd0, 1'b1, EMPTY_MARK}});
    stim_rows.push_back('{OP_UNUSED, 32'd7, 1'b1, '{STAT_ABSENT, 5'd0, 1'b1, EMPTY_MARK}});
    stim_rows.push_back('{OP_INSERT, 32'h7FFF_FFFF, 1'b1,
                          '{STAT_OK, 5'd1, 1'b0, 32'h7FFF_FFFF}});
    stim_rows.push_back('{OP_INSERT, 32'h8000_0000, 1'b1,
                          '{STAT_OK, 5'd2, 1'b0, 32'h8000_0000}});
    stim_rows.push_back('{OP_INSERT, EMPTY_MARK, 1'b0, '0});
    stim_rows.push_back('{OP_INSERT, 32'd0, 1'b0, '0});
    stim_rows.push_back('{OP_INSERT, 32'd0, 1'b0, '0});
    stim_rows.push_back('{OP_SEARCH, 32'd0, 1'b0, '0});
    stim_rows.push_back('{OP_SEARCH, 32'd1, 1'b0, '0});
    stim_rows.push_back('{OP_UNUSED, 32'hFFFF_FFFF, 1'b0, '0});
    stim_rows.push_back('{OP_REMOVE, 32'h8000_0000, 1'b0, '0});
    // four entries held here, twelve more fill the table
    for (int i = 0; i < 12; i++) stim_rows.push_back('{OP_INSERT, 32'(i) - 32'd1, 1'b0, '0});
    stim_rows.push_back('{OP_INSERT, 32'd3, 1'b1, '{STAT_FULL, 5'd16, 1'b0, EMPTY_MARK}});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idx = 0;
    foreach (stim_rows[i]) begin
      issue_item(idx, stim_rows[i]);
      idx++;
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      issue_item(idx, pick_random_item(idx));
      idx++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sorted_table_insert_search_remove.f -----
+incdir+rtl
rtl/stis_pkg.sv
rtl/stis_ram.sv
rtl/stis_ctrl.sv
rtl/stis_datapath.sv
rtl/sorted_table_insert_search_remove.sv
tb/tb_sorted_table_insert_search_remove.sv
